@@ rtl/mvt_pkg.sv @@
`default_nettype none

package mvt_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned ELEM_W = 32;
  localparam int unsigned PROD_W = 2 * ELEM_W;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam int unsigned DIM    = 4;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned CMD_W  = 3;

  // Default number of fraction bits of the fixed-point format.
  localparam int unsigned FRAC_BITS_DEF = 16;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Command codes carried by each item.
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_ROW = 3'd0,
    CMD_LOAD_COL = 3'd1,
    CMD_XFORM    = 3'd2,
    CMD_READ_ROW = 3'd3,
    CMD_READ_COL = 3'd4
  } cmd_t;

  // Write and read-select control from the pipeline to the matrix store.
  typedef struct packed {
    logic             we;
    logic             is_col;
    logic [IDX_W-1:0] idx;
  } mat_ctl_t;

endpackage

`default_nettype wire

@@ rtl/matrix_vector_transform_core.sv @@
`default_nettype none

// 4x4 matrix times 4-vector in signed fixed point with FRAC_BITS fraction bits
// (Q16.16 by default). The matrix resets to identity. Each item is a row load,
// column load (no result), row or column readback, or a transform whose four
// outputs are the exact dot products shifted right by FRAC_BITS (toward minus
// infinity) and clamped to 32 bits, with out_saturated set when any clamped.
// One item is accepted every cycle while in_stall is low; a result passes through
// the input register, the product register of sixteen 32x32 multipliers and
// the output register. A load updates the matrix as it leaves the input
// register, so the very next transform already sees it.

module matrix_vector_transform_core
  import mvt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [CMD_W-1:0] in_cmd,
  input  wire logic [IDX_W-1:0] in_index,
  input  wire elem_t            in_elem_a,
  input  wire elem_t            in_elem_b,
  input  wire elem_t            in_elem_c,
  input  wire elem_t            in_elem_d,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output elem_t                 out_a,
  output elem_t                 out_b,
  output elem_t                 out_c,
  output elem_t                 out_d,
  output logic                  out_saturated
);

  // Pipeline advance conditions, from the output back to the input.
  logic adv1, adv2, adv3;

  logic             v1_r;
  logic [CMD_W-1:0] cmd1_r;
  logic [IDX_W-1:0] idx1_r;
  elem_t            e1_r [DIM];

  logic  v2_r, v2_nxt;
  logic  xf2_r;
  prod_t p2_r  [DIM*DIM];
  elem_t rd2_r [DIM];

  logic  out_valid_r;
  elem_t res3_r [DIM];
  logic  sat3_r;

  logic     is_load, is_col, is_xform, is_read;
  mat_ctl_t mctl;
  elem_t    ent   [DIM*DIM];
  elem_t    rdata [DIM];
  elem_t    dres  [DIM];
  logic     dsat  [DIM];

  assign adv3     = !out_valid_r || !out_stall;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      cmd1_r  <= in_cmd;
      idx1_r  <= in_index;
      e1_r[0] <= in_elem_a;
      e1_r[1] <= in_elem_b;
      e1_r[2] <= in_elem_c;
      e1_r[3] <= in_elem_d;
    end
  end

  // Command decode for the item in the input register.
  always_comb begin
    is_load  = 1'b0;
    is_col   = 1'b0;
    is_xform = 1'b0;
    is_read  = 1'b0;
    unique case (cmd_t'(cmd1_r))
      CMD_LOAD_ROW: is_load = 1'b1;
      CMD_LOAD_COL: begin
        is_load = 1'b1;
        is_col  = 1'b1;
      end
      CMD_XFORM:    is_xform = 1'b1;
      CMD_READ_ROW: is_read = 1'b1;
      CMD_READ_COL: begin
        is_read = 1'b1;
        is_col  = 1'b1;
      end
      default: ;
    endcase
  end

  // A load writes once, as its item leaves the input register.
  assign mctl.we     = v1_r && adv2 && is_load;
  assign mctl.is_col = is_col;
  assign mctl.idx    = idx1_r;

  mvt_matrix #(
    .FRAC_BITS (FRAC_BITS)
  ) u_matrix (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mctl),
    .wdata (e1_r),
    .ent   (ent),
    .rdata (rdata)
  );

  // Product stage: only transforms and reads carry on as results.
  assign v2_nxt = v1_r && (is_xform || is_read);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v2_nxt) begin
      xf2_r <= is_xform;
      rd2_r <= rdata;
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          p2_r[r*DIM+c] <= PROD_W'(ent[r*DIM+c]) * PROD_W'(e1_r[c]);
        end
      end
    end
  end

  // One dot product with shift and clamp per output element.
  for (genvar r = 0; r < DIM; r++) begin : g_dot
    prod_t row_p [DIM];

    for (genvar c = 0; c < DIM; c++) begin : g_tap
      assign row_p[c] = p2_r[r*DIM+c];
    end

    mvt_dot_sat #(
      .FRAC_BITS (FRAC_BITS)
    ) u_dot (
      .prod (row_p),
      .res  (dres[r]),
      .sat  (dsat[r])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv3) begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2_r) begin
      res3_r <= xf2_r ? dres : rd2_r;
      sat3_r <= xf2_r && (dsat[0] || dsat[1] || dsat[2] || dsat[3]);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_a         = res3_r[0];
  assign out_b         = res3_r[1];
  assign out_c         = res3_r[2];
  assign out_d         = res3_r[3];
  assign out_saturated = sat3_r;

endmodule

`default_nettype wire

@@ rtl/mvt_matrix.sv @@
`default_nettype none

module mvt_matrix
  import mvt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mat_ctl_t ctl,
  input  wire elem_t    wdata [DIM],
  output elem_t         ent   [DIM*DIM],
  output elem_t         rdata [DIM]
);

  elem_t ent_r [DIM*DIM];

  // Entries are row-major; each one is written by a row or a column load.
  for (genvar r = 0; r < DIM; r++) begin : g_row
    for (genvar c = 0; c < DIM; c++) begin : g_col
      logic hit;

      assign hit = ctl.we && ((!ctl.is_col && (ctl.idx == IDX_W'(r))) ||
                              ( ctl.is_col && (ctl.idx == IDX_W'(c))));

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          ent_r[r*DIM+c] <= (r == c) ? (ELEM_W'(1) << FRAC_BITS) : '0;
        end else if (hit) begin
          ent_r[r*DIM+c] <= ctl.is_col ? wdata[r] : wdata[c];
        end
      end

      assign ent[r*DIM+c] = ent_r[r*DIM+c];
    end
  end

  // Readback selects one row or one column.
  always_comb begin
    for (int k = 0; k < DIM; k++) begin
      rdata[k] = ctl.is_col ? ent_r[{IDX_W'(k), ctl.idx}]
                            : ent_r[{ctl.idx, IDX_W'(k)}];
    end
  end

endmodule

`default_nettype wire

@@ rtl/mvt_dot_sat.sv @@
`default_nettype none

module mvt_dot_sat
  import mvt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire prod_t prod [DIM],
  output elem_t      res,
  output logic       sat
);

  sum_t                  sum;
  sum_t                  shifted;
  logic [SUM_W-ELEM_W:0] upper;

  // Exact sum of the four products, then a flooring shift.
  assign sum     = SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]) + SUM_W'(prod[3]);
  assign shifted = sum >>> FRAC_BITS;
  assign upper   = shifted[SUM_W-1:ELEM_W-1];

  // Clamp when the shifted value does not fit a signed 32-bit result.
  always_comb begin
    sat = !((&upper) || !(|upper));
    if (!sat) begin
      res = shifted[ELEM_W-1:0];
    end else if (shifted[SUM_W-1]) begin
      res = {1'b1, {(ELEM_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(ELEM_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

@@ dv/matrix_product_checker.sv @@
`default_nettype none

// Watches both channels of the transform core. It keeps its own copy of the
// matrix and works out the result of every accepted item. Each delivered
// result is checked against the oldest one still owed.
module matrix_product_checker
  import mvt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_stall,
  input  wire logic [CMD_W-1:0] in_cmd,
  input  wire logic [IDX_W-1:0] in_index,
  input  wire elem_t            in_elem_a,
  input  wire elem_t            in_elem_b,
  input  wire elem_t            in_elem_c,
  input  wire elem_t            in_elem_d,
  input  wire logic             out_valid,
  input  wire logic             out_stall,
  input  wire elem_t            out_a,
  input  wire elem_t            out_b,
  input  wire elem_t            out_c,
  input  wire elem_t            out_d,
  input  wire logic             out_saturated,
  output int                    mismatch_count,
  output int                    results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // Limits of a signed 32-bit output, held at the width of the dot-product sum.
  localparam sum_t Q_MAX = (sum_t'(1) <<< (ELEM_W - 1)) - sum_t'(1);
  localparam sum_t Q_MIN = -(sum_t'(1) <<< (ELEM_W - 1));

  typedef struct packed {
    elem_t a;
    elem_t b;
    elem_t c;
    elem_t d;
    logic  sat;
  } vec_result_t;

  elem_t       matrix_q [DIM][DIM];
  vec_result_t owed_results [$];
  int          errors;

  // Update the matrix copy for one item and queue the result it causes.
  task automatic apply_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                            input elem_t e0, input elem_t e1, input elem_t e2,
                            input elem_t e3);
    elem_t       vec [DIM];
    elem_t       row_out [DIM];
    sum_t        acc;
    logic        sat;
    vec_result_t res;
    vec[0] = e0;
    vec[1] = e1;
    vec[2] = e2;
    vec[3] = e3;
    sat = 1'b0;
    case (cmd)
      CMD_LOAD_ROW: begin
        for (int k = 0; k < DIM; k++) matrix_q[idx][k] = vec[k];
      end
      CMD_LOAD_COL: begin
        for (int k = 0; k < DIM; k++) matrix_q[k][idx] = vec[k];
      end
      CMD_XFORM: begin
        // Exact sum of four products, floor shift, then clamp to 32 bits.
        for (int r = 0; r < DIM; r++) begin
          acc = '0;
          for (int k = 0; k < DIM; k++) begin
            acc = acc + sum_t'(prod_t'(matrix_q[r][k]) * prod_t'(vec[k]));
          end
          acc = acc >>> FRAC_BITS;
          if (acc > Q_MAX) begin
            acc = Q_MAX;
            sat = 1'b1;
          end else if (acc < Q_MIN) begin
            acc = Q_MIN;
            sat = 1'b1;
          end
          row_out[r] = acc[ELEM_W-1:0];
        end
        res = '{a: row_out[0], b: row_out[1], c: row_out[2], d: row_out[3], sat: sat};
        owed_results.push_back(res);
      end
      CMD_READ_ROW: begin
        res = '{a: matrix_q[idx][0], b: matrix_q[idx][1], c: matrix_q[idx][2],
                d: matrix_q[idx][3], sat: 1'b0};
        owed_results.push_back(res);
      end
      CMD_READ_COL: begin
        res = '{a: matrix_q[0][idx], b: matrix_q[1][idx], c: matrix_q[2][idx],
                d: matrix_q[3][idx], sat: 1'b0};
        owed_results.push_back(res);
      end
      default: begin
        // Spare command codes leave the matrix alone and give nothing back.
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [ELEM_W-1:0] want,
                               input logic [ELEM_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Results are checked before the item of the same edge is predicted.
  always @(posedge clk) begin : watch
    vec_result_t want;
    if (!rst_n) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          matrix_q[r][c] = (r == c) ? elem_t'(1 << FRAC_BITS) : elem_t'(0);
        end
      end
      owed_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h %h %h %h sat %b",
                   $time, out_a, out_b, out_c, out_d, out_saturated);
          errors++;
        end else begin
          want = owed_results.pop_front();
          compare_field("out_a", want.a, out_a);
          compare_field("out_b", want.b, out_b);
          compare_field("out_c", want.c, out_c);
          compare_field("out_d", want.d, out_d);
          compare_field("out_saturated", {{(ELEM_W-1){1'b0}}, want.sat},
                        {{(ELEM_W-1){1'b0}}, out_saturated});
        end
      end
      if (in_valid && !in_stall) begin
        apply_item(in_cmd, in_index, in_elem_a, in_elem_b, in_elem_c, in_elem_d);
      end
    end
    mismatch_count <= errors;
    results_owed   <= owed_results.size();
  end

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mvt_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned HOLD_CYCLES  = 300;

  // Command codes the block does not use.
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  localparam elem_t ELEM_MAX = 32'sh7FFF_FFFF;
  localparam elem_t ELEM_MIN = elem_t'(32'h8000_0000);
  localparam elem_t ONE_Q    = elem_t'(1 << FRAC_BITS_DEF);
  localparam elem_t RAW_LSB  = elem_t'(1);
  localparam elem_t ALL_ONES = elem_t'(32'hFFFF_FFFF);

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [CMD_W-1:0] in_cmd = CMD_READ_ROW;
  logic [IDX_W-1:0] in_index = '0;
  elem_t            in_elem_a = '0;
  elem_t            in_elem_b = '0;
  elem_t            in_elem_c = '0;
  elem_t            in_elem_d = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  elem_t            out_a;
  elem_t            out_b;
  elem_t            out_c;
  elem_t            out_d;
  logic             out_saturated;
  int               mismatch_count;
  int               results_owed;

  // Shared between the sender and the receiver processes.
  logic             calm = 1'b0;
  logic             hold_req = 1'b0;

  always #5 clk = ~clk;

  matrix_vector_transform_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_index      (in_index),
    .in_elem_a     (in_elem_a),
    .in_elem_b     (in_elem_b),
    .in_elem_c     (in_elem_c),
    .in_elem_d     (in_elem_d),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_a         (out_a),
    .out_b         (out_b),
    .out_c         (out_c),
    .out_d         (out_d),
    .out_saturated (out_saturated)
  );

  matrix_product_checker product_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_index       (in_index),
    .in_elem_a      (in_elem_a),
    .in_elem_b      (in_elem_b),
    .in_elem_c      (in_elem_c),
    .in_elem_d      (in_elem_d),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_a          (out_a),
    .out_b          (out_b),
    .out_c          (out_c),
    .out_d          (out_d),
    .out_saturated  (out_saturated),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Element values: full range, small Q16.16 numbers, extremes, mid magnitudes.
  function automatic elem_t rand_elem();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return elem_t'($urandom);
    if (r < 70) return elem_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    if (r < 85) begin
      case ($urandom_range(0, 6))
        0: return ELEM_MAX;
        1: return ELEM_MIN;
        2: return ONE_Q;
        3: return -ONE_Q;
        4: return ALL_ONES;
        5: return RAW_LSB;
        default: return '0;
      endcase
    end
    return elem_t'($urandom) >>> $urandom_range(0, 24);
  endfunction

  // Offer one item, after an optional gap, and wait until it is taken.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                           input elem_t a, input elem_t b, input elem_t c,
                           input elem_t d);
    int unsigned gap;
    gap = calm ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_cmd    <= cmd;
    in_index  <= idx;
    in_elem_a <= a;
    in_elem_b <= b;
    in_elem_c <= c;
    in_elem_d <= d;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random(input logic [CMD_W-1:0] cmd);
    send_item(cmd, IDX_W'($urandom_range(0, DIM - 1)), rand_elem(), rand_elem(),
              rand_elem(), rand_elem());
  endtask

  // Receiver: random stalls, calm stretches, and one long hold-off.
  initial begin : receiver
    bit          hold_served;
    int unsigned n;
    hold_served = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (calm) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        n = idle_len();
        if (n == 0) begin
          out_stall <= 1'b0;
          n = $urandom_range(1, 4);
        end else begin
          out_stall <= 1'b1;
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned      sent;
    int unsigned      r;
    logic [CMD_W-1:0] cmd;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity after reset, read back both ways and applied to extreme vectors.
    send_item(CMD_READ_ROW, 2'd0, '0, '0, '0, '0);
    send_item(CMD_READ_COL, 2'd3, '0, '0, '0, '0);
    send_item(CMD_XFORM, 2'd2, ELEM_MAX, ELEM_MIN, '0, ALL_ONES);

    // Extreme entries so that sums clamp on both sides.
    send_item(CMD_LOAD_ROW, 2'd0, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
    send_item(CMD_LOAD_COL, 2'd1, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);
    send_item(CMD_XFORM, 2'd0, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
    send_item(CMD_XFORM, 2'd1, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);
    send_item(CMD_XFORM, 2'd3, ELEM_MIN, ELEM_MAX, ELEM_MIN, ELEM_MAX);
    send_item(CMD_READ_ROW, 2'd0, '0, '0, '0, '0);
    send_item(CMD_READ_COL, 2'd1, '0, '0, '0, '0);

    // Tiny negative sums must round toward minus infinity.
    send_item(CMD_LOAD_ROW, 2'd2, RAW_LSB, RAW_LSB, RAW_LSB, RAW_LSB);
    send_item(CMD_XFORM, 2'd3, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);

    // Spare codes are ignored, so the following read shows nothing changed.
    send_item(CMD_SPARE_FIRST, 2'd1, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
    send_item(CMD_SPARE_FIRST + 3'd1, 2'd2, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);
    send_item(CMD_SPARE_LAST, 2'd3, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    send_item(CMD_READ_ROW, 2'd3, '0, '0, '0, '0);
    send_item(CMD_READ_COL, 2'd2, '0, '0, '0, '0);

    // A fully random matrix, then columns 0 and 3 reloaded as plus and minus unit columns.
    for (int i = 0; i < DIM; i++) send_random(CMD_LOAD_ROW);
    send_random(CMD_XFORM);
    send_item(CMD_LOAD_COL, 2'd0, ONE_Q, '0, '0, '0);
    send_item(CMD_LOAD_COL, 2'd3, '0, '0, '0, -ONE_Q);

    // Random part: mostly transforms between row and column updates.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 150 == 0) calm <= ($urandom_range(0, 3) == 0);
      if (sent == 400) hold_req <= 1'b1;
      r = $urandom_range(0, 99);
      if (r < 50) cmd = CMD_XFORM;
      else if (r < 63) cmd = CMD_LOAD_ROW;
      else if (r < 76) cmd = CMD_LOAD_COL;
      else if (r < 85) cmd = CMD_READ_ROW;
      else if (r < 94) cmd = CMD_READ_COL;
      else cmd = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      send_random(cmd);
      if (cmd <= CMD_READ_COL) sent++;
    end
    in_valid <= 1'b0;

    // Drain whatever the block still owes, then allow the pipeline to settle.
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Generous upper bound on the whole run.
  initial begin : watchdog
    #8ms;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
